FILE: hdl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// shared types, command codes and hash constants for the stream hasher
// ----------------------------------------------------------------------------
package shs_pkg;

    typedef logic [31:0] t_word;
    typedef logic [7:0][31:0] t_words8;

    typedef enum logic {
        CMD_ABSORB = 1'b0,
        CMD_FINISH = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FOLD,
        ST_OUT
    } t_state;

    // schedule window control
    typedef struct packed {
        logic       wr_en;
        logic       shift;
        logic [5:0] wr_pos;
        logic [7:0] wr_byte;
    } t_sched_ctl;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LAST_RND = 6'd63;
    localparam logic [2:0] LAST_IDX = 3'd7;

    localparam t_words8 HASH_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam t_word K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

FILE: hdl/shs_if.sv
// ----------------------------------------------------------------------------
// shs_in_if / shs_out_if
// valid/ready channels carrying message beats in and digest beats out
// ----------------------------------------------------------------------------
interface shs_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface shs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

FILE: hdl/shs_sched.sv
// ----------------------------------------------------------------------------
// shs_sched
// block buffer and message schedule window, sixteen words
// ----------------------------------------------------------------------------
module shs_sched
    import shs_pkg::*;
(
    input  logic       i_clk,
    input  t_sched_ctl i_ctl,
    output t_word      o_w
);

    t_word r_w [16];
    t_word n_w15;

    function automatic t_word ssig0(input t_word x);
        ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic t_word ssig1(input t_word x);
        ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    assign n_w15 = ssig1(r_w[14]) + r_w[9] + ssig0(r_w[1]) + r_w[0];
    assign o_w   = r_w[0];

    // bytes land big-endian within each word
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= n_w15;
        end else if (i_ctl.wr_en) begin
            r_w[i_ctl.wr_pos[5:2]][{~i_ctl.wr_pos[1:0], 3'b000} +: 8] <= i_ctl.wr_byte;
        end
    end

endmodule

FILE: hdl/shs_round.sv
// ----------------------------------------------------------------------------
// shs_round
// one compression round on the eight working words
// ----------------------------------------------------------------------------
module shs_round
    import shs_pkg::*;
(
    input  t_words8 i_v,
    input  t_word   i_k,
    input  t_word   i_w,
    output t_words8 o_v
);

    t_word sig1;
    t_word sig0;
    t_word choose;
    t_word major;
    t_word t1;

    assign sig1   = {i_v[4][5:0], i_v[4][31:6]} ^ {i_v[4][10:0], i_v[4][31:11]}
                  ^ {i_v[4][24:0], i_v[4][31:25]};
    assign sig0   = {i_v[0][1:0], i_v[0][31:2]} ^ {i_v[0][12:0], i_v[0][31:13]}
                  ^ {i_v[0][21:0], i_v[0][31:22]};
    assign choose = (i_v[4] & i_v[5]) ^ (~i_v[4] & i_v[6]);
    assign major  = (i_v[0] & i_v[1]) ^ (i_v[0] & i_v[2]) ^ (i_v[1] & i_v[2]);
    assign t1     = i_v[7] + sig1 + choose + i_k + i_w;

    always_comb begin
        o_v[7] = i_v[6];
        o_v[6] = i_v[5];
        o_v[5] = i_v[4];
        o_v[4] = i_v[3] + t1;
        o_v[3] = i_v[2];
        o_v[2] = i_v[1];
        o_v[1] = i_v[0];
        o_v[0] = t1 + sig0 + major;
    end

endmodule

FILE: hdl/sha256_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// SHA-256 over a byte stream, one round per clock on a shared round unit
// ----------------------------------------------------------------------------
// Each input beat is either one message byte (absorb) or a finish command.
// An absorb beat writes one byte to the block buffer; the 64th byte of a
// block also starts the compression, which runs the single round unit
// for every round and then folds the working words into the hash. A
// finish beat writes the padding one byte per cycle up to the end of the
// block, compresses, and does so a second time when the 0x80 marker lands
// at offset 56 or later; it then sends the digest as eight 32-bit output
// beats, big-endian word order, word_index 0 to 7, last_word on the
// eighth. The input channel is not ready while padding, compressing or
// sending the digest. After the eighth beat is taken the fill count,
// length, hash and working words are back at their reset values and the
// next byte starts a new message.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top
    import shs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    shs_in_if.sink    i_in,
    shs_out_if.source o_out
);

    // control and datapath state
    t_state     r_state;
    t_state     n_state;
    logic [5:0] r_fill;     // bytes held in the block buffer
    logic [63:0] r_len;     // message length in bits, wraps
    t_words8    r_h;        // hash state
    t_words8    r_v;        // working words a..h
    logic [5:0] r_round;
    logic [2:0] r_oidx;
    logic       r_pad;      // inside a finish sequence
    logic       r_first;    // next pad byte is the 0x80 marker
    logic       r_len_ok;   // this block takes the length field
    logic       r_final;    // compression in flight closes the message

    logic       in_acc;
    logic       out_acc;
    t_sched_ctl sched_ctl;
    t_word      sched_w;
    t_words8    round_v;
    logic [7:0] pad_byte;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;

    // block buffer and schedule window
    shs_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (sched_ctl),
        .o_w   (sched_w)
    );

    // shared round unit
    shs_round u_round (
        .i_v (r_v),
        .i_k (K_TAB[r_round]),
        .i_w (sched_w),
        .o_v (round_v)
    );

    // padding byte: marker, zeros, then the big-endian bit length
    always_comb begin
        if (r_first) begin
            pad_byte = PAD_BYTE;
        end else if (r_len_ok && (r_fill >= LEN_POS)) begin
            pad_byte = r_len[{~r_fill[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.command == CMD_FINISH) begin
                        n_state = ST_PAD;
                    end else if (r_fill == LAST_POS) begin
                        n_state = ST_COMP;
                    end
                end
            end
            ST_PAD: begin
                if (r_fill == LAST_POS) begin
                    n_state = ST_COMP;
                end
            end
            ST_COMP: begin
                if (r_round == LAST_RND) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (!r_pad) begin
                    n_state = ST_IDLE;
                end else if (r_final) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_OUT: begin
                if (out_acc && (r_oidx == LAST_IDX)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        i_in.ready        = (r_state == ST_IDLE);
        o_out.valid       = (r_state == ST_OUT);
        o_out.digest_word = r_h[r_oidx];
        o_out.word_index  = r_oidx;
        o_out.last_word   = (r_oidx == LAST_IDX);
        sched_ctl.shift   = (r_state == ST_COMP);
        sched_ctl.wr_pos  = r_fill;
        sched_ctl.wr_en   = (r_state == ST_PAD)
                          || (in_acc && (i_in.command == CMD_ABSORB));
        sched_ctl.wr_byte = (r_state == ST_PAD) ? pad_byte : i_in.data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_len    <= '0;
            r_h      <= HASH_IV;
            r_v      <= HASH_IV;
            r_round  <= '0;
            r_oidx   <= '0;
            r_pad    <= 1'b0;
            r_first  <= 1'b0;
            r_len_ok <= 1'b0;
            r_final  <= 1'b0;
        end else begin
            if (sched_ctl.wr_en) begin
                r_fill <= r_fill + 6'd1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_in.command == CMD_FINISH) begin
                            r_pad    <= 1'b1;
                            r_first  <= 1'b1;
                            r_len_ok <= 1'b0;
                        end else begin
                            r_len <= r_len + 64'd8;
                        end
                    end
                end
                ST_PAD: begin
                    r_first <= 1'b0;
                    // marker early enough: length fits in this block
                    if (r_first && (r_fill < LEN_POS)) begin
                        r_len_ok <= 1'b1;
                    end
                    if (r_fill == LAST_POS) begin
                        r_final  <= r_len_ok;
                        r_len_ok <= 1'b1;
                    end
                end
                ST_COMP: begin
                    r_v     <= round_v;
                    r_round <= r_round + 6'd1;
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                        r_v[i] <= r_h[i] + r_v[i];
                    end
                end
                ST_OUT: begin
                    if (out_acc) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == LAST_IDX) begin
                            r_len   <= '0;
                            r_h     <= HASH_IV;
                            r_v     <= HASH_IV;
                            r_pad   <= 1'b0;
                            r_final <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // input and output sides never both open
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while digest beat pending");

    // the round loop runs to its end without a break
    a_round_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMP) && (r_round != LAST_RND) |=> (r_state == ST_COMP))
        else $error("compression left early");

    // after the last digest beat the block is back at its start point
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && o_out.last_word |=> (r_fill == 6'd0) && (r_len == 64'd0)
            && (r_h == HASH_IV) && (r_state == ST_IDLE))
        else $error("state not reinitialised after digest");

    // an absorb beat always lengthens the message by one byte
    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in.command == CMD_ABSORB) |=> (r_len == $past(r_len) + 64'd8))
        else $error("bit length not advanced");

endmodule
